// ===== src/psu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG scanline unfilter package
// Shared constants, register indexes, filter codes and the queue entry type.
// ----------------------------------------------------------------------------
package psu_pkg;

   localparam int MAX_ROW_BYTES = 4096;
   localparam int COL_W         = $clog2(MAX_ROW_BYTES);
   localparam int LEN_W         = COL_W + 1;
   localparam int ROW_BYTES_W   = 13;
   localparam int CMP_W         = (LEN_W > ROW_BYTES_W) ? LEN_W : ROW_BYTES_W;
   localparam int BPP_W         = 3;
   localparam int HEIGHT_W      = 16;
   localparam int CSR_DATA_W    = 16;
   localparam int CSR_INDEX_W   = 2;
   localparam int HIST_DEPTH    = 4;
   localparam int HIST_IDX_W    = $clog2(HIST_DEPTH);
   localparam int Q_DEPTH       = 4;
   localparam int Q_PTR_W       = $clog2(Q_DEPTH);

   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_BYTES       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTES_PER_PIXEL = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT    = 2'd2;

   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } filter_type;

   typedef struct packed {
      logic [ROW_BYTES_W-1:0] row_bytes;
      logic [BPP_W-1:0]       bytes_per_pixel;
      logic [HEIGHT_W-1:0]    image_height;
   } cfg_type;

   typedef struct packed {
      logic [7:0]       raw;
      logic [COL_W-1:0] col;
      filter_type       filt;
      logic             row_start;
      logic             first_row;
      logic             last_col;
      logic             last_row;
   } qent_type;

endpackage

// ===== src/psu_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module psu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/psu_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG unfilter front end
// Takes stream bytes, latches the filter type of each row and tags every data
// byte with its column, row position and filter before queueing it.
// ----------------------------------------------------------------------------
module psu_front (
   input  logic              clock,
   input  logic              reset,
   input  psu_pkg::cfg_type  cfg,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_stream_byte,
   input  logic              q_full,
   output logic              q_push,
   output psu_pkg::qent_type q_ent
);

   typedef enum logic [1:0] {
      ST_FILTER = 2'b01,
      ST_DATA   = 2'b10
   } state_type;

   state_type                      state_ff, state_in;
   logic [psu_pkg::COL_W-1:0]      col_ff, col_in;
   logic [psu_pkg::HEIGHT_W-1:0]   row_ff, row_in;
   psu_pkg::filter_type            filt_ff, filt_in;

   logic                           accept;
   logic [psu_pkg::CMP_W-1:0]      len_eff;
   logic [psu_pkg::CMP_W-1:0]      col_cmp;
   logic [psu_pkg::CMP_W-1:0]      col_sel;
   logic [psu_pkg::CMP_W:0]        col_next;
   logic [psu_pkg::HEIGHT_W-1:0]   height_eff;
   logic [psu_pkg::HEIGHT_W:0]     row_next;
   logic                           last_col;
   logic                           last_row;
   psu_pkg::filter_type            filt_dec;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      // Row length: zero acts as one, anything past the line buffer saturates.
      if (cfg.row_bytes == '0) begin
         len_eff = psu_pkg::CMP_W'(1);
      end else if (psu_pkg::CMP_W'(cfg.row_bytes) > psu_pkg::CMP_W'(psu_pkg::MAX_ROW_BYTES)) begin
         len_eff = psu_pkg::CMP_W'(psu_pkg::MAX_ROW_BYTES);
      end else begin
         len_eff = psu_pkg::CMP_W'(cfg.row_bytes);
      end
      height_eff = (cfg.image_height == '0) ? psu_pkg::HEIGHT_W'(1) : cfg.image_height;

      col_cmp  = psu_pkg::CMP_W'(col_ff);
      col_sel  = (col_cmp >= len_eff) ? (len_eff - psu_pkg::CMP_W'(1)) : col_cmp;
      col_next = {1'b0, col_sel} + (psu_pkg::CMP_W + 1)'(1);
      last_col = (col_next >= {1'b0, len_eff});
      row_next = {1'b0, row_ff} + (psu_pkg::HEIGHT_W + 1)'(1);
      last_row = (row_next >= {1'b0, height_eff});

      if (req_stream_byte <= 8'(psu_pkg::FILT_PAETH)) begin
         filt_dec = psu_pkg::filter_type'(req_stream_byte[2:0]);
      end else begin
         filt_dec = psu_pkg::FILT_NONE;
      end
   end

   always_comb begin
      q_ent.raw       = req_stream_byte;
      q_ent.col       = col_sel[psu_pkg::COL_W-1:0];
      q_ent.filt      = filt_ff;
      q_ent.row_start = (col_ff == '0);
      q_ent.first_row = (row_ff == '0);
      q_ent.last_col  = last_col;
      q_ent.last_row  = last_row;
   end

   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      filt_in  = filt_ff;
      q_push   = 1'b0;
      case (state_ff)
         ST_FILTER: begin
            if (accept) begin
               filt_in  = filt_dec;
               col_in   = '0;
               state_in = ST_DATA;
            end
         end
         ST_DATA: begin
            if (accept) begin
               q_push = 1'b1;
               if (last_col) begin
                  col_in   = '0;
                  row_in   = last_row ? '0 : row_next[psu_pkg::HEIGHT_W-1:0];
                  state_in = ST_FILTER;
               end else begin
                  col_in = col_next[psu_pkg::COL_W-1:0];
               end
            end
         end
         default: begin
            state_in = ST_FILTER;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILTER;
         col_ff   <= '0;
         row_ff   <= '0;
         filt_ff  <= psu_pkg::FILT_NONE;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         filt_ff  <= filt_in;
      end
   end

endmodule

// ===== src/psu_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG unfilter byte queue
// Small FIFO of tagged data bytes between the front end and the back end.
// ----------------------------------------------------------------------------
module psu_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  psu_pkg::qent_type push_ent,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output psu_pkg::qent_type head_ent
);

   psu_pkg::qent_type             ent_ff [psu_pkg::Q_DEPTH];
   logic [psu_pkg::Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [psu_pkg::Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [psu_pkg::Q_PTR_W:0]     count_ff, count_in;
   logic                          do_push;
   logic                          do_pop;

   assign full       = (count_ff == (psu_pkg::Q_PTR_W + 1)'(psu_pkg::Q_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_ent   = ent_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + psu_pkg::Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + psu_pkg::Q_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (psu_pkg::Q_PTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (psu_pkg::Q_PTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         ent_ff[wr_ptr_ff] <= push_ent;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== src/psu_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG unfilter back end
// Reads the byte above from the line buffer, applies the row's filter with
// the left and above-left history, writes the result back and holds it in
// the output register.
// ----------------------------------------------------------------------------
module psu_back (
   input  logic              clock,
   input  logic              reset,
   input  psu_pkg::cfg_type  cfg,
   input  logic              head_valid,
   input  psu_pkg::qent_type head_ent,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_pixel_byte,
   output logic              rsp_row_end,
   output logic              rsp_image_end
);

   logic                           b_valid_ff, b_valid_in;
   psu_pkg::qent_type              b_ent_ff;
   logic                           byp_hit_ff;
   logic [7:0]                     byp_data_ff;
   logic [7:0]                     left_ff [psu_pkg::HIST_DEPTH];
   logic [7:0]                     upl_ff  [psu_pkg::HIST_DEPTH];
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [7:0]                     rsp_pixel_byte_ff;
   logic                           rsp_row_end_ff;
   logic                           rsp_image_end_ff;

   logic                           out_free;
   logic                           b_adv;
   logic                           b_free;
   logic [7:0]                     rd_data;
   logic [7:0]                     above;
   logic [7:0]                     a_val;
   logic [7:0]                     c_val;
   logic [psu_pkg::HIST_IDX_W-1:0] hidx;
   logic [8:0]                     sum9;
   logic signed [9:0]              d_pa;
   logic signed [9:0]              d_pb;
   logic signed [9:0]              d_pc;
   logic [9:0]                     pa;
   logic [9:0]                     pb;
   logic [9:0]                     pc;
   logic [7:0]                     paeth;
   logic [7:0]                     pred;
   logic [7:0]                     res;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign b_adv    = b_valid_ff && out_free;
   assign b_free   = !b_valid_ff || b_adv;
   assign pop      = head_valid && b_free;

   // The line buffer is read as a byte enters the compute stage and written
   // as it leaves, so the same column of the next row may be written in the
   // very cycle it is read; that case is caught by the bypass below.
   psu_ram #(
      .WIDTH (8),
      .DEPTH (psu_pkg::MAX_ROW_BYTES)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (b_adv),
      .wr_addr (b_ent_ff.col),
      .wr_data (res),
      .rd_en   (pop),
      .rd_addr (head_ent.col),
      .rd_data (rd_data)
   );

   always_comb begin
      // Filter unit: zero acts as one byte, anything above four as four.
      if (cfg.bytes_per_pixel == '0) begin
         hidx = '0;
      end else if (cfg.bytes_per_pixel > psu_pkg::BPP_W'(psu_pkg::HIST_DEPTH)) begin
         hidx = psu_pkg::HIST_IDX_W'(psu_pkg::HIST_DEPTH - 1);
      end else begin
         hidx = psu_pkg::HIST_IDX_W'(cfg.bytes_per_pixel - psu_pkg::BPP_W'(1));
      end

      if (b_ent_ff.first_row) begin
         above = '0;
      end else if (byp_hit_ff) begin
         above = byp_data_ff;
      end else begin
         above = rd_data;
      end

      a_val = b_ent_ff.row_start ? '0 : left_ff[hidx];
      c_val = b_ent_ff.row_start ? '0 : upl_ff[hidx];

      sum9 = {1'b0, a_val} + {1'b0, above};

      d_pa = $signed({2'b00, above}) - $signed({2'b00, c_val});
      d_pb = $signed({2'b00, a_val}) - $signed({2'b00, c_val});
      d_pc = $signed({2'b00, a_val}) + $signed({2'b00, above})
           - $signed({1'b0, c_val, 1'b0});
      pa   = (d_pa < 0) ? 10'(-d_pa) : 10'(d_pa);
      pb   = (d_pb < 0) ? 10'(-d_pb) : 10'(d_pb);
      pc   = (d_pc < 0) ? 10'(-d_pc) : 10'(d_pc);

      if (pa <= pb && pa <= pc) begin
         paeth = a_val;
      end else if (pb <= pc) begin
         paeth = above;
      end else begin
         paeth = c_val;
      end

      case (b_ent_ff.filt)
         psu_pkg::FILT_SUB:   pred = a_val;
         psu_pkg::FILT_UP:    pred = above;
         psu_pkg::FILT_AVG:   pred = sum9[8:1];
         psu_pkg::FILT_PAETH: pred = paeth;
         default:             pred = '0;
      endcase

      res = b_ent_ff.raw + pred;
   end

   assign b_valid_in   = pop ? 1'b1 : (b_adv ? 1'b0 : b_valid_ff);
   assign rsp_valid_in = b_adv ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (pop) begin
         b_ent_ff    <= head_ent;
         byp_hit_ff  <= b_adv && (b_ent_ff.col == head_ent.col);
         byp_data_ff <= res;
      end
      if (b_adv) begin
         rsp_pixel_byte_ff <= res;
         rsp_row_end_ff    <= b_ent_ff.last_col;
         rsp_image_end_ff  <= b_ent_ff.last_col && b_ent_ff.last_row;
         left_ff[0]        <= res;
         upl_ff[0]         <= above;
         for (int k = 1; k < psu_pkg::HIST_DEPTH; k++) begin
            left_ff[k] <= b_ent_ff.row_start ? '0 : left_ff[k-1];
            upl_ff[k]  <= b_ent_ff.row_start ? '0 : upl_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_byte = rsp_pixel_byte_ff;
   assign rsp_row_end    = rsp_row_end_ff;
   assign rsp_image_end  = rsp_image_end_ff;

endmodule

// ===== src/png_scanline_unfilter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG scanline unfilter, top level
// Rebuilds filtered PNG scanlines from the inflated byte stream.
// ----------------------------------------------------------------------------
// The block takes one stream byte per cycle, filter type bytes included, and
// keeps that pace without gaps while the result side is ready. A filter type
// byte occupies its input cycle and gives no result; every data byte gives
// one result after passing through the queue, the registered read of the
// line buffer that supplies the byte above, and the output register. The
// line buffer has no clearing pass, so the block is ready in the cycle after
// reset. Configuration writes belong between images or while no byte is in
// flight.
module png_scanline_unfilter_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_stream_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_pixel_byte,
   output logic                            rsp_row_end,
   output logic                            rsp_image_end,
   input  logic                            csr_wr_en,
   input  logic [psu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [psu_pkg::CSR_DATA_W-1:0]  csr_wr_data
);

   psu_pkg::cfg_type  cfg_ff;
   logic              q_full;
   logic              q_push;
   psu_pkg::qent_type q_push_ent;
   logic              q_pop;
   logic              q_head_valid;
   psu_pkg::qent_type q_head_ent;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_bytes       <= psu_pkg::ROW_BYTES_W'(1);
         cfg_ff.bytes_per_pixel <= psu_pkg::BPP_W'(1);
         cfg_ff.image_height    <= psu_pkg::HEIGHT_W'(1);
      end else if (csr_wr_en) begin
         case (csr_index)
            psu_pkg::CSR_ROW_BYTES:
               cfg_ff.row_bytes <= csr_wr_data[psu_pkg::ROW_BYTES_W-1:0];
            psu_pkg::CSR_BYTES_PER_PIXEL:
               cfg_ff.bytes_per_pixel <= csr_wr_data[psu_pkg::BPP_W-1:0];
            psu_pkg::CSR_IMAGE_HEIGHT:
               cfg_ff.image_height <= csr_wr_data[psu_pkg::HEIGHT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   psu_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_stream_byte (req_stream_byte),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_ent           (q_push_ent)
   );

   psu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_ent   (q_push_ent),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_ent   (q_head_ent)
   );

   psu_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .head_valid     (q_head_valid),
      .head_ent       (q_head_ent),
      .pop            (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel_byte (rsp_pixel_byte),
      .rsp_row_end    (rsp_row_end),
      .rsp_image_end  (rsp_image_end)
   );

endmodule

// ===== src/psu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG unfilter port checker
// Watches the top-level ports of the unfilter block over time.
// ----------------------------------------------------------------------------
module psu_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_pixel_byte,
   input logic       rsp_row_end,
   input logic       rsp_image_end
);

   // A result waiting for its transfer must not vanish.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before its transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_pixel_byte) && $stable(rsp_row_end) && $stable(rsp_image_end))
      else $error("result changed while stalled");

   // The end of the image is always also the end of a row.
   a_image_end_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_image_end |-> rsp_row_end)
      else $error("image end without row end");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown straight after reset");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("input not ready after reset");

endmodule

bind png_scanline_unfilter_top psu_checker u_psu_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_pixel_byte (rsp_pixel_byte),
   .rsp_row_end    (rsp_row_end),
   .rsp_image_end  (rsp_image_end)
);

// ===== test/tb_png_scanline_unfilter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG scanline unfilter testbench
// Drives filtered PNG rows through the unfilter block and compares each
// reconstructed byte, with its row and image end flags, against a local
// predictor. The run covers each filter type, the register extremes, register
// changes part-way through an image, a row length past the line buffer, and
// random images. Both handshake sides stall at random save in the final tests.
// ----------------------------------------------------------------------------
module tb_png_scanline_unfilter_top;

   localparam logic [psu_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 12;

   typedef struct packed {
      logic [7:0] pixel;
      logic       row_end;
      logic       image_end;
   } pixel_result_type;

   logic                            clock;
   logic                            reset           = 1'b1;
   logic                            req_valid       = 1'b0;
   logic                            req_ready;
   logic [7:0]                      req_stream_byte = 8'd0;
   logic                            rsp_valid;
   logic                            rsp_ready       = 1'b0;
   logic [7:0]                      rsp_pixel_byte;
   logic                            rsp_row_end;
   logic                            rsp_image_end;
   logic                            csr_wr_en       = 1'b0;
   logic [psu_pkg::CSR_INDEX_W-1:0] csr_index       = '0;
   logic [psu_pkg::CSR_DATA_W-1:0]  csr_wr_data     = '0;

   // Predictor state and its copy of the registers.
   logic [7:0]                      prev_row [0:psu_pkg::MAX_ROW_BYTES-1];
   logic [7:0]                      left_bytes [0:psu_pkg::HIST_DEPTH-1];
   logic [7:0]                      upleft_bytes [0:psu_pkg::HIST_DEPTH-1];
   int unsigned                     col_pos;
   int unsigned                     row_pos;
   logic [7:0]                      cur_filter;
   logic                            awaiting_type;
   logic [psu_pkg::ROW_BYTES_W-1:0] cfg_row_bytes;
   logic [psu_pkg::BPP_W-1:0]       cfg_bpp;
   logic [psu_pkg::HEIGHT_W-1:0]    cfg_height;

   pixel_result_type pending_pixels [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatches    = 0;
   int bytes_sent    = 0;
   int pixels_seen   = 0;
   int images_done   = 0;
   int midway_writes = 0;

   png_scanline_unfilter_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_stream_byte (req_stream_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_byte  (rsp_pixel_byte),
      .rsp_row_end     (rsp_row_end),
      .rsp_image_end   (rsp_image_end),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d results outstanding", pending_pixels.size());
      $display("end of test: mismatches");
      $finish;
   end

   function automatic void clear_model();
      for (int k = 0; k < psu_pkg::MAX_ROW_BYTES; k++) prev_row[k] = 8'd0;
      for (int k = 0; k < psu_pkg::HIST_DEPTH; k++) begin
         left_bytes[k]   = 8'd0;
         upleft_bytes[k] = 8'd0;
      end
      col_pos       = 0;
      row_pos       = 0;
      cur_filter    = 8'd0;
      awaiting_type = 1'b1;
      cfg_row_bytes = psu_pkg::ROW_BYTES_W'(1);
      cfg_bpp       = psu_pkg::BPP_W'(1);
      cfg_height    = psu_pkg::HEIGHT_W'(1);
   endfunction

   // Works out what one stream byte produces and queues it.
   function automatic void unfilter_byte(input logic [7:0] raw);
      int unsigned         len, bpp, height, col;
      int                  p, pa, pb, pc;
      logic [7:0]          a, b, c, pred;
      psu_pkg::filter_type filt;
      pixel_result_type    item;
      if (awaiting_type) begin
         cur_filter    = raw;
         awaiting_type = 1'b0;
         col_pos       = 0;
         for (int k = 0; k < psu_pkg::HIST_DEPTH; k++) begin
            left_bytes[k]   = 8'd0;
            upleft_bytes[k] = 8'd0;
         end
         return;
      end
      len = (cfg_row_bytes == 0) ? 1 : cfg_row_bytes;
      if (len > psu_pkg::MAX_ROW_BYTES) len = psu_pkg::MAX_ROW_BYTES;
      bpp = (cfg_bpp == 0) ? 1 : ((cfg_bpp > psu_pkg::HIST_DEPTH) ? psu_pkg::HIST_DEPTH : cfg_bpp);
      height = (cfg_height == 0) ? 1 : cfg_height;
      // A row shortened part-way through ends on the next byte.
      col = (col_pos >= len) ? len - 1 : col_pos;
      a = left_bytes[bpp-1];
      c = upleft_bytes[bpp-1];
      b = (row_pos == 0) ? 8'd0 : prev_row[col];
      filt = (cur_filter > 8'(psu_pkg::FILT_PAETH)) ? psu_pkg::FILT_NONE
                                                     : psu_pkg::filter_type'(cur_filter[2:0]);
      case (filt)
         psu_pkg::FILT_SUB:   pred = a;
         psu_pkg::FILT_UP:    pred = b;
         psu_pkg::FILT_AVG:   pred = 8'((9'(a) + 9'(b)) >> 1);
         psu_pkg::FILT_PAETH: begin
            p  = int'(a) + int'(b) - int'(c);
            pa = p - int'(a);
            pb = p - int'(b);
            pc = p - int'(c);
            if (pa < 0) pa = -pa;
            if (pb < 0) pb = -pb;
            if (pc < 0) pc = -pc;
            if (pa <= pb && pa <= pc) pred = a;
            else if (pb <= pc)        pred = b;
            else                      pred = c;
         end
         default:             pred = 8'd0;
      endcase
      item.pixel = raw + pred;
      for (int k = psu_pkg::HIST_DEPTH - 1; k > 0; k--) begin
         left_bytes[k]   = left_bytes[k-1];
         upleft_bytes[k] = upleft_bytes[k-1];
      end
      left_bytes[0]   = item.pixel;
      upleft_bytes[0] = b;
      prev_row[col]   = item.pixel;
      item.row_end    = (col + 1 >= len);
      item.image_end  = item.row_end && (row_pos + 1 >= height);
      pending_pixels.push_back(item);
      if (item.row_end) begin
         awaiting_type = 1'b1;
         col_pos       = 0;
         if (item.image_end) begin
            row_pos = 0;
            images_done++;
         end else begin
            row_pos = row_pos + 1;
         end
      end else begin
         col_pos = col + 1;
      end
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      mismatches++;
      $display("%t mismatch on %s: got %0h, want %0h", $realtime, field, got, want);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         pixels_seen++;
         if (pending_pixels.size() == 0) begin
            report_mismatch("unexpected result", rsp_pixel_byte, 0);
         end else begin
            automatic pixel_result_type want = pending_pixels.pop_front();
            if (rsp_pixel_byte !== want.pixel)
               report_mismatch("pixel_byte", rsp_pixel_byte, want.pixel);
            if (rsp_row_end !== want.row_end)
               report_mismatch("row_end", rsp_row_end, want.row_end);
            if (rsp_image_end !== want.image_end)
               report_mismatch("image_end", rsp_image_end, want.image_end);
         end
      end
   end

   // Receiver stalls at random.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Valid is left high after a transfer; a gap lowers it on a later edge.
   task automatic send_byte(input logic [7:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_stream_byte <= value;
      unfilter_byte(value);
      bytes_sent++;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Holds the sender off until every queued result has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   // Quiet point for register writes: results in, then the pipeline settles.
   task automatic drain();
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [psu_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [psu_pkg::CSR_DATA_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      case (idx)
         psu_pkg::CSR_ROW_BYTES:       cfg_row_bytes = value[psu_pkg::ROW_BYTES_W-1:0];
         psu_pkg::CSR_BYTES_PER_PIXEL: cfg_bpp       = value[psu_pkg::BPP_W-1:0];
         psu_pkg::CSR_IMAGE_HEIGHT:    cfg_height    = value[psu_pkg::HEIGHT_W-1:0];
         default:                      ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_row(input logic [7:0] filt, input int data_bytes);
      send_byte(filt);
      repeat (data_bytes) send_byte(8'($urandom));
   endtask

   task automatic test_reset_defaults();
      // One byte per row, one row per image straight out of reset.
      send_byte(8'(psu_pkg::FILT_NONE));
      send_byte(8'hFF);
   endtask

   task automatic test_every_filter();
      logic [7:0] data [0:13];
      data = '{8'hFF, 8'h01, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'hFE,
               8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h00, 8'h00};
      drain();
      write_csr(psu_pkg::CSR_ROW_BYTES, 16'd2);
      write_csr(psu_pkg::CSR_BYTES_PER_PIXEL, 16'd0);
      write_csr(psu_pkg::CSR_IMAGE_HEIGHT, 16'd7);
      // The first row runs Paeth with nothing above; the last row, which ends the image, has an unknown type.
      send_byte(8'(psu_pkg::FILT_PAETH)); send_byte(data[0]);  send_byte(data[1]);
      send_byte(8'(psu_pkg::FILT_NONE));  send_byte(data[2]);  send_byte(data[3]);
      send_byte(8'(psu_pkg::FILT_SUB));   send_byte(data[4]);  send_byte(data[5]);
      send_byte(8'(psu_pkg::FILT_UP));    send_byte(data[6]);  send_byte(data[7]);
      send_byte(8'(psu_pkg::FILT_AVG));   send_byte(data[8]);  send_byte(data[9]);
      send_byte(8'(psu_pkg::FILT_PAETH)); send_byte(data[10]); send_byte(data[11]);
      send_byte(8'hFF);                   send_byte(data[12]); send_byte(data[13]);
   endtask

   task automatic test_register_extremes();
      drain();
      // Upper data bits beyond each register are dropped.
      write_csr(psu_pkg::CSR_ROW_BYTES, 16'hE000);
      write_csr(psu_pkg::CSR_BYTES_PER_PIXEL, 16'hFFFF);
      write_csr(psu_pkg::CSR_IMAGE_HEIGHT, 16'd0);
      write_csr(CSR_UNUSED, 16'hFFFF);
      send_byte(8'(psu_pkg::FILT_SUB));
      send_byte(8'h80);
      drain();
      write_csr(psu_pkg::CSR_BYTES_PER_PIXEL, 16'hFFF8);
      write_csr(psu_pkg::CSR_ROW_BYTES, 16'd1);
      send_byte(8'(psu_pkg::FILT_UP));
      send_byte(8'h7F);
   endtask

   task automatic test_mid_image_changes();
      drain();
      write_csr(psu_pkg::CSR_ROW_BYTES, 16'd6);
      write_csr(psu_pkg::CSR_BYTES_PER_PIXEL, 16'd2);
      write_csr(psu_pkg::CSR_IMAGE_HEIGHT, 16'hFFFF);
      send_row(8'(psu_pkg::FILT_SUB), 6);
      send_row(8'(psu_pkg::FILT_PAETH), 4);
      // Shrink the row while part-way through it: the next byte ends the row.
      drain();
      write_csr(psu_pkg::CSR_ROW_BYTES, 16'd3);
      write_csr(psu_pkg::CSR_BYTES_PER_PIXEL, 16'd3);
      midway_writes += 2;
      send_byte(8'($urandom));
      // Lower the height to no more than the rows already done: this row closes the image.
      drain();
      write_csr(psu_pkg::CSR_IMAGE_HEIGHT, 16'd2);
      midway_writes++;
      send_row(8'(psu_pkg::FILT_AVG), 3);
   endtask

   task automatic test_row_past_buffer();
      drain();
      // A length past the line buffer saturates and does not end the row early.
      write_csr(psu_pkg::CSR_ROW_BYTES, 16'h1FFF);
      write_csr(psu_pkg::CSR_BYTES_PER_PIXEL, 16'd4);
      write_csr(psu_pkg::CSR_IMAGE_HEIGHT, 16'd2);
      send_row(8'($urandom_range(int'(psu_pkg::FILT_NONE), int'(psu_pkg::FILT_PAETH))), 100);
      drain();
      write_csr(psu_pkg::CSR_ROW_BYTES, 16'd101);
      midway_writes++;
      send_byte(8'($urandom));
      send_row(8'(psu_pkg::FILT_PAETH), 101);
   endtask

   task automatic test_random_images(input int budget);
      int start, len, height, pick;
      logic [7:0] filt;
      start = bytes_sent;
      while (bytes_sent - start < budget) begin
         drain();
         pick = $urandom_range(99);
         if (pick < 5)       len = 0;
         else if (pick < 75) len = $urandom_range(1, 16);
         else                len = $urandom_range(17, 80);
         height = $urandom_range(0, 6);
         write_csr(psu_pkg::CSR_ROW_BYTES, psu_pkg::CSR_DATA_W'(len));
         write_csr(psu_pkg::CSR_BYTES_PER_PIXEL, psu_pkg::CSR_DATA_W'($urandom_range(0, 7)));
         write_csr(psu_pkg::CSR_IMAGE_HEIGHT, psu_pkg::CSR_DATA_W'(height));
         if (len == 0) len = 1;
         if (height == 0) height = 1;
         for (int r = 0; r < height; r++) begin
            if ($urandom_range(99) < 85)
               filt = 8'($urandom_range(int'(psu_pkg::FILT_NONE), int'(psu_pkg::FILT_PAETH)));
            else
               filt = 8'($urandom_range(int'(psu_pkg::FILT_PAETH) + 1, 255));
            send_byte(filt);
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(199) == 0) wait_for_results();
               send_byte(8'($urandom));
            end
         end
      end
   endtask

   initial begin
      clear_model();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 6;
      recv_idle_pct = 63;
      test_reset_defaults();
      test_every_filter();
      test_register_extremes();
      test_random_images(250);

      send_idle_pct = 63;
      recv_idle_pct = 6;
      test_mid_image_changes();
      test_random_images(250);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_row_past_buffer();
      test_random_images(250);
      drain();

      $display("sent %0d stream bytes and checked %0d reconstructed bytes over %0d images",
               bytes_sent, pixels_seen, images_done);
      $display("all five filters, unknown types, register extremes and %0d mid-image writes",
               midway_writes);
      if (mismatches == 0 && pending_pixels.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, pending_pixels.size());
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/psu_pkg.sv
src/psu_ram.sv
src/psu_front.sv
src/psu_queue.sv
src/psu_back.sv
src/png_scanline_unfilter_top.sv
src/psu_checker.sv
test/tb_png_scanline_unfilter_top.sv
